// ===== hdl/alc_pkg.sv =====
`default_nettype none

package alc_pkg;

   // Command codes carried on the request tuser field.
   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_FIRST  = 2'd1,
      CMD_NEXT   = 2'd2,
      CMD_REMOVE = 2'd3
   } cmd_type;

   // Sequencer states of the list controller.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SHIFT,
      ST_EMIT
   } state_type;

   localparam int unsigned DATA_FIELD_WIDTH  = 32;
   localparam int unsigned COUNT_FIELD_WIDTH = 7;
   localparam int unsigned RSP_TDATA_WIDTH   = 40;

endpackage

`default_nettype wire

// ===== hdl/alc_ram.sv =====
`default_nettype none

// Simple dual-port synchronous memory: one write port, one read port,
// registered read data.
module alc_ram #(
   parameter int unsigned DEPTH = 64,
   parameter int unsigned WIDTH = 32,
   parameter int unsigned AW    = 6
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== hdl/array_list_with_cursor_unit.sv =====
`default_nettype none

// Bounded ordered list of data words with a read cursor. Each request
// transaction carries a command in req_tuser (insert, first, next, remove
// current) and a word in req_tdata that only insert uses; each request gives
// exactly one response transaction with a success flag in rsp_tuser and the
// data word and entry count in rsp_tdata. The words live in a synchronous
// memory with one write and one read port, so commands are processed one at
// a time: insert writes its word into the memory when it is accepted, first
// and next make one memory read, and remove makes one memory read and moves
// the later entries down one place per cycle through the memory's single
// read and write port, one write per entry behind the removed one. A failing
// command skips the memory step. The response sits in an output register,
// so the next request is accepted while the previous response still waits
// to be taken; a finished command only stalls when that register is still
// full. Stored words are DATA_WIDTH bits wide; the response word is the
// stored word cut or zero-extended to 32 bits, and the entry count field is
// the count modulo 128. The memory is not cleared at reset; only entries
// below the count are ever read.
module array_list_with_cursor_unit #(
   parameter int unsigned CAPACITY   = 64,
   parameter int unsigned DATA_WIDTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] data_in
   input  wire logic [1:0]  req_tuser,   // [1:0] cmd
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // [31:0] data_out, [38:32] entry_count, [39] zero
   output logic             rsp_tuser    // [0] ok
);

   localparam int unsigned AW = $clog2(CAPACITY);
   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam int unsigned DFW = alc_pkg::DATA_FIELD_WIDTH;
   localparam int unsigned CFW = alc_pkg::COUNT_FIELD_WIDTH;

   alc_pkg::state_type state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           cur_none_ff, cur_none_in;
   logic [AW-1:0]  cur_ix_ff, cur_ix_in;
   logic [AW-1:0]  shift_ix_ff, shift_ix_in;
   logic           is_remove_ff, is_remove_in;
   logic           res_ok_ff, res_ok_in;
   logic [DFW-1:0] res_data_ff, res_data_in;

   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_ok_ff, rsp_ok_in;
   logic [DFW-1:0] rsp_data_ff, rsp_data_in;
   logic [CFW-1:0] rsp_count_ff, rsp_count_in;

   logic                  mem_we;
   logic [AW-1:0]         mem_waddr;
   logic [DATA_WIDTH-1:0] mem_wdata;
   logic [AW-1:0]         mem_raddr;
   logic [DATA_WIDTH-1:0] mem_rdata;

   alc_pkg::cmd_type      cmd;
   logic [DATA_WIDTH+DFW-1:0] in_ext;
   logic [DATA_WIDTH+DFW-1:0] out_ext;
   logic [CW:0]           count_w;
   logic [CW:0]           cur_next_w;
   logic [CW:0]           shift_next_w;
   logic [CW:0]           shift_skip_w;
   logic [CW+CFW-1:0]     count_ext;

   alc_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (DATA_WIDTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign cmd          = alc_pkg::cmd_type'(req_tuser);
   assign in_ext       = {{DATA_WIDTH{1'b0}}, req_tdata};
   assign out_ext      = {{DFW{1'b0}}, mem_rdata};
   assign count_w      = (CW+1)'(count_ff);
   assign cur_next_w   = (CW+1)'(cur_ix_ff) + (CW+1)'(1);
   assign shift_next_w = (CW+1)'(shift_ix_ff) + (CW+1)'(1);
   assign shift_skip_w = (CW+1)'(shift_ix_ff) + (CW+1)'(2);
   assign count_ext    = {{CFW{1'b0}}, count_ff};

   assign req_tready = (state_ff == alc_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_count_ff, rsp_data_ff};
   assign rsp_tuser  = rsp_ok_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      cur_none_in  = cur_none_ff;
      cur_ix_in    = cur_ix_ff;
      shift_ix_in  = shift_ix_ff;
      is_remove_in = is_remove_ff;
      res_ok_in    = res_ok_ff;
      res_data_in  = res_data_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_count_in = rsp_count_ff;
      mem_we       = 1'b0;
      mem_waddr    = count_ff[AW-1:0];
      mem_wdata    = in_ext[DATA_WIDTH-1:0];
      mem_raddr    = cur_ix_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         alc_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               res_ok_in    = 1'b0;
               res_data_in  = '0;
               is_remove_in = 1'b0;
               state_in     = alc_pkg::ST_EMIT;
               case (cmd)
                  alc_pkg::CMD_INSERT: begin
                     if (count_w < (CW+1)'(CAPACITY)) begin
                        mem_we    = 1'b1;
                        count_in  = count_ff + CW'(1);
                        res_ok_in = 1'b1;
                     end
                  end
                  alc_pkg::CMD_FIRST: begin
                     if (count_ff != '0) begin
                        cur_none_in = 1'b0;
                        cur_ix_in   = '0;
                        mem_raddr   = '0;
                        state_in    = alc_pkg::ST_READ;
                     end
                  end
                  alc_pkg::CMD_NEXT: begin
                     if (cur_none_ff) begin
                        if (count_ff != '0) begin
                           cur_none_in = 1'b0;
                           cur_ix_in   = '0;
                           mem_raddr   = '0;
                           state_in    = alc_pkg::ST_READ;
                        end
                     end else if (cur_next_w < count_w) begin
                        cur_ix_in = cur_next_w[AW-1:0];
                        mem_raddr = cur_next_w[AW-1:0];
                        state_in  = alc_pkg::ST_READ;
                     end
                  end
                  alc_pkg::CMD_REMOVE: begin
                     if (!cur_none_ff && ((CW+1)'(cur_ix_ff) < count_w)) begin
                        is_remove_in = 1'b1;
                        mem_raddr    = cur_ix_ff;
                        state_in     = alc_pkg::ST_READ;
                     end
                  end
                  default: begin
                     state_in = alc_pkg::ST_EMIT;
                  end
               endcase
            end
         end

         alc_pkg::ST_READ: begin
            // Read data for the entry under the cursor arrives this cycle.
            res_ok_in   = 1'b1;
            res_data_in = out_ext[DFW-1:0];
            state_in    = alc_pkg::ST_EMIT;
            if (is_remove_ff) begin
               count_in = count_ff - CW'(1);
               if (cur_ix_ff == '0) begin
                  cur_none_in = 1'b1;
               end else begin
                  cur_ix_in = cur_ix_ff - AW'(1);
               end
               // Entries behind the removed one move down, one per cycle.
               if (cur_next_w < count_w) begin
                  shift_ix_in = cur_ix_ff;
                  mem_raddr   = cur_next_w[AW-1:0];
                  state_in    = alc_pkg::ST_SHIFT;
               end
            end
         end

         alc_pkg::ST_SHIFT: begin
            // count_ff already holds the reduced count here.
            mem_we    = 1'b1;
            mem_waddr = shift_ix_ff;
            mem_wdata = mem_rdata;
            if (shift_next_w < count_w) begin
               shift_ix_in = shift_next_w[AW-1:0];
               mem_raddr   = shift_skip_w[AW-1:0];
            end else begin
               state_in = alc_pkg::ST_EMIT;
            end
         end

         alc_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = res_ok_ff;
               rsp_data_in  = res_data_ff;
               rsp_count_in = count_ext[CFW-1:0];
               state_in     = alc_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = alc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= alc_pkg::ST_IDLE;
         count_ff     <= '0;
         cur_none_ff  <= 1'b1;
         cur_ix_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cur_none_ff  <= cur_none_in;
         cur_ix_ff    <= cur_ix_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ix_ff  <= shift_ix_in;
      is_remove_ff <= is_remove_in;
      res_ok_ff    <= res_ok_in;
      res_data_ff  <= res_data_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_count_ff <= rsp_count_in;
   end

endmodule

`default_nettype wire
